FILE: design/cji_pkg.sv
// Shared types, codes and constants of the cycloid joint interpolator.
// Holds the command and result word layouts and the sine entry builder.
// No dependencies.
package cji_pkg;

    // command function codes
    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_RESTART = 2'd1;
    localparam logic [1:0] FUNC_STEP    = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEAD       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_ARM   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_LEG   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_LEG  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_ARM  = 3'd5;

    // joint count registers and their reset values
    localparam int NUM_LEN_REGS = 5;
    localparam logic [3:0] LEN_RESET [NUM_LEN_REGS] = '{4'd2, 4'd4, 4'd6, 4'd6, 4'd4};
    localparam logic [9:0] STEP_COUNT_RESET = 10'd1;

    // fixed-point constants
    localparam logic signed [22:0] INV_2PI_Q24 = 23'sd2670177;
    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam int FRAC_ONE    = 65536;

    // command word
    typedef struct packed {
        logic [1:0]         func;
        logic [2:0]         chain_sel;
        logic [2:0]         joint_sel;
        logic signed [15:0] start_angle;
        logic signed [15:0] final_angle;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [2:0]         out_chain;
        logic [2:0]         out_joint;
        logic signed [15:0] angle;
        logic               chain_finished;
        logic               last;
    } out_word_t;

    // sine in Q1.16 from a first-quadrant angle in Q30, odd series to x^15
    // full scale of plus or minus one needs the eighteenth bit
    function automatic logic signed [17:0] sine_from_x(longint x, bit neg);
        longint x2;
        longint term;
        longint sum;
        longint r;
        x2   = (x * x) / ONE_Q30;
        term = x;
        sum  = x;
        term = -((term * x2) / ONE_Q30) / 6;
        sum  = sum + term;
        term = -((term * x2) / ONE_Q30) / 20;
        sum  = sum + term;
        term = -((term * x2) / ONE_Q30) / 42;
        sum  = sum + term;
        term = -((term * x2) / ONE_Q30) / 72;
        sum  = sum + term;
        term = -((term * x2) / ONE_Q30) / 110;
        sum  = sum + term;
        term = -((term * x2) / ONE_Q30) / 156;
        sum  = sum + term;
        term = -((term * x2) / ONE_Q30) / 210;
        sum  = sum + term;
        r = (sum + 64'sd8192) >>> 14;
        if (r < 0)
        begin
            r = 0;
        end
        if (r > 65536)
        begin
            r = 65536;
        end
        if (neg)
        begin
            r = -r;
        end
        return 18'(r);
    endfunction

endpackage

FILE: design/cji_stream_if.sv
// Valid/ready channels of the cycloid joint interpolator.
// Command channel and result channel; word layouts come from cji_pkg.
interface cji_cmd_if;
    logic             valid;
    logic             ready;
    cji_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cji_res_if;
    logic              valid;
    logic              ready;
    cji_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/cycloid_joint_interpolator.sv
// Cycloid joint interpolator: top level with joint store, divider and profile datapath.
// Depends on cji_pkg and the channel interfaces in cji_stream_if.sv.
//
// Load, restart and ignored command words, and steps of a chain with no
// joints, are taken in the idle state, which they do not leave. A step word
// runs the bit-serial divider that forms k/N and the sine index, then the
// sine table read, the 1/(2*pi) product and the profile, and then for each
// of the chain's J joints (J at most 8) a joint store read, the shared
// diff*profile multiply and the rounding, add and saturation, with each
// joint's output held while the result side stalls. Commands are taken one
// at a time; the next word is taken as soon as the last result of a step
// sits in the output register. The joint store has no clearing pass: a
// joint that was never loaded reads back whatever the store holds.
module cycloid_joint_interpolator #(
    parameter int CHAINS           = 5,
    parameter int JOINTS_PER_CHAIN = 8,
    parameter int SINE_ENTRIES     = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cji_cmd_if.sink                           cmd,
    cji_res_if.source                         res,
    input  logic                              cfg_we,
    input  logic [cji_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cji_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DEPTH   = CHAINS * JOINTS_PER_CHAIN;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CH_W    = (CHAINS > 1) ? $clog2(CHAINS) : 1;
    localparam int MAX_OUT = (JOINTS_PER_CHAIN < 8) ? JOINTS_PER_CHAIN : 8;
    localparam int IDX_W   = $clog2(SINE_ENTRIES);
    localparam int QB_W    = $clog2(SINE_ENTRIES + 1);
    localparam int DIV_W   = 26;
    localparam int DCNT_W  = $clog2(DIV_W);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_SIN, S_STERM, S_PROF, S_JRD, S_JMUL, S_JOUT
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [9:0] step_count_reg;
    logic [3:0] chain_len_reg [cji_pkg::NUM_LEN_REGS];

    // step counters
    logic [9:0] step_ctr_reg [CHAINS];
    logic       ctr_any;

    // joint store: {diff, start}
    logic [32:0]       joint_mem [DEPTH];
    logic [32:0]       mem_q_reg;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;

    // sine table
    logic signed [17:0] sine_rom [SINE_ENTRIES];
    logic [IDX_W-1:0]   sine_idx;
    logic [QB_W-1:0]    qb;

    // per-step registers
    logic [2:0]        chain_reg;
    logic [9:0]        n_reg;
    logic              fin_reg;
    logic [3:0]        cnt_reg;
    logic [3:0]        joint_q_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [DIV_W-1:0]  div_a_reg, div_b_reg;
    logic [9:0]        rem_a_reg, rem_b_reg;
    logic signed [17:0] sine_q_reg;
    logic signed [39:0] sprod_reg;
    logic signed [17:0] prof_reg;
    logic signed [34:0] jprod_reg;
    logic signed [15:0] start_reg;
    logic               out_valid_reg;
    cji_pkg::out_word_t out_word_reg;

    // accept-side decode
    logic              cmd_fire;
    logic              chain_ok;
    logic              step_fire;
    logic              load_fire;
    logic [CH_W-1:0]   chain_idx;
    logic [9:0]        n_eff;
    logic [9:0]        ctr_cur;
    logic [9:0]        ctr_new;
    logic [9:0]        kk;
    logic [3:0]        len_sel;
    logic [3:0]        cnt_next;

    // divider step
    logic [10:0] a_t, b_t, n_ext;
    logic        a_ge, b_ge;

    // profile and joint arithmetic
    logic signed [39:0] sround;
    logic signed [15:0] sterm;
    logic signed [34:0] jround;
    logic signed [18:0] jterm;
    logic signed [19:0] asum;
    logic signed [15:0] angle_sat;
    logic               out_load;
    logic               last_joint;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign chain_ok  = int'(cmd.data.chain_sel) < CHAINS;
    assign chain_idx = cmd.data.chain_sel[CH_W-1:0];
    assign step_fire = cmd_fire && chain_ok && (cmd.data.func == cji_pkg::FUNC_STEP);
    assign load_fire = cmd_fire && chain_ok && (cmd.data.func == cji_pkg::FUNC_LOAD);

    // counter advance and joint count for the chain being stepped
    always_comb
    begin
        n_eff   = (step_count_reg == 10'd0) ? 10'd1 : step_count_reg;
        ctr_cur = step_ctr_reg[chain_idx];
        ctr_new = (ctr_cur < n_eff) ? ctr_cur + 10'd1 : ctr_cur;
        kk      = (ctr_new > n_eff) ? n_eff : ctr_new;
        len_sel = (int'(cmd.data.chain_sel) < cji_pkg::NUM_LEN_REGS)
                ? chain_len_reg[cmd.data.chain_sel] : 4'd0;
        cnt_next = (int'(len_sel) > MAX_OUT) ? 4'(MAX_OUT) : len_sel;
    end

    // one restoring step for both quotients
    always_comb
    begin
        n_ext = {1'b0, n_reg};
        a_t   = {rem_a_reg, div_a_reg[DIV_W-1]};
        b_t   = {rem_b_reg, div_b_reg[DIV_W-1]};
        a_ge  = a_t >= n_ext;
        b_ge  = b_t >= n_ext;
    end

    // sine index from the second quotient, full turn wraps to zero
    assign qb       = div_b_reg[QB_W-1:0];
    assign sine_idx = (qb == QB_W'(SINE_ENTRIES)) ? '0 : qb[IDX_W-1:0];

    // sine term and joint result rounding
    always_comb
    begin
        sround = sprod_reg + 40'sd8388608;
        sterm  = 16'(sround >>> 24);
        jround = jprod_reg + 35'sd32768;
        jterm  = 19'(jround >>> 16);
        asum   = 20'(jterm) + 20'(start_reg);
        if (asum > 20'sd32767)
        begin
            angle_sat = 16'sd32767;
        end
        else if (asum < -20'sd32768)
        begin
            angle_sat = -16'sd32768;
        end
        else
        begin
            angle_sat = asum[15:0];
        end
    end

    assign last_joint = (joint_q_reg + 4'd1 == cnt_reg);
    assign out_load   = (state_reg == S_JOUT) && (!out_valid_reg || res.ready);

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (step_fire && (cnt_next != 4'd0))
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = S_SIN;
                end
            end
            S_SIN:   state_next = S_STERM;
            S_STERM: state_next = S_PROF;
            S_PROF:  state_next = S_JRD;
            S_JRD:   state_next = S_JMUL;
            S_JMUL:  state_next = S_JOUT;
            S_JOUT:
            begin
                if (out_load)
                begin
                    state_next = last_joint ? S_IDLE : S_JRD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state, loop counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
            joint_q_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (step_fire)
            begin
                div_cnt_reg <= DCNT_W'(DIV_W - 1);
                joint_q_reg <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
            end
            else if (out_load && !last_joint)
            begin
                joint_q_reg <= joint_q_reg + 4'd1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= cji_pkg::STEP_COUNT_RESET;
            for (int i = 0; i < cji_pkg::NUM_LEN_REGS; i++)
            begin
                chain_len_reg[i] <= cji_pkg::LEN_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index) inside
                cji_pkg::REG_STEP_COUNT: step_count_reg <= cfg_data[9:0];
                [cji_pkg::REG_HEAD:cji_pkg::REG_RIGHT_ARM]:
                begin
                    chain_len_reg[3'(cfg_index - cji_pkg::REG_HEAD)] <= cfg_data[3:0];
                end
                default: ;
            endcase
        end
    end

    // step counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHAINS; i++)
            begin
                step_ctr_reg[i] <= '0;
            end
        end
        else if (cmd_fire && (cmd.data.func == cji_pkg::FUNC_RESTART))
        begin
            for (int i = 0; i < CHAINS; i++)
            begin
                step_ctr_reg[i] <= '0;
            end
        end
        else if (step_fire)
        begin
            step_ctr_reg[chain_idx] <= ctr_new;
        end
    end

    always_comb
    begin
        ctr_any = 1'b0;
        for (int i = 0; i < CHAINS; i++)
        begin
            ctr_any = ctr_any | (|step_ctr_reg[i]);
        end
    end

    // joint store, one write and one registered read
    assign mem_we  = load_fire && (int'(cmd.data.joint_sel) < JOINTS_PER_CHAIN);
    assign wr_addr = ADDR_W'(int'(cmd.data.chain_sel) * JOINTS_PER_CHAIN
                             + int'(cmd.data.joint_sel));
    assign rd_addr = ADDR_W'(int'(chain_reg) * JOINTS_PER_CHAIN + int'(joint_q_reg));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            joint_mem[wr_addr] <= {17'(cmd.data.final_angle) - 17'(cmd.data.start_angle),
                                   cmd.data.start_angle};
        end
        mem_q_reg <= joint_mem[rd_addr];
    end

    // sine table built at elaboration from the first quadrant
    for (genvar gi = 0; gi < SINE_ENTRIES; gi++)
    begin : g_sine
        localparam longint P0  = 4 * gi;
        localparam bit     NEG = (P0 >= 2 * SINE_ENTRIES);
        localparam longint P1  = NEG ? P0 - 2 * SINE_ENTRIES : P0;
        localparam longint P2  = (P1 > SINE_ENTRIES) ? 2 * SINE_ENTRIES - P1 : P1;
        localparam longint XQ  = (P2 * cji_pkg::PI_Q30 + SINE_ENTRIES) / (2 * SINE_ENTRIES);
        assign sine_rom[gi] = cji_pkg::sine_from_x(XQ, NEG);
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            chain_reg <= cmd.data.chain_sel;
            n_reg     <= n_eff;
            fin_reg   <= (ctr_new >= n_eff);
            cnt_reg   <= cnt_next;
            div_a_reg <= {kk, 16'd0};
            div_b_reg <= DIV_W'(kk) * DIV_W'(SINE_ENTRIES);
            rem_a_reg <= '0;
            rem_b_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            rem_a_reg <= a_ge ? 10'(a_t - n_ext) : a_t[9:0];
            rem_b_reg <= b_ge ? 10'(b_t - n_ext) : b_t[9:0];
            div_a_reg <= {div_a_reg[DIV_W-2:0], a_ge};
            div_b_reg <= {div_b_reg[DIV_W-2:0], b_ge};
        end
        sine_q_reg <= sine_rom[sine_idx];
        sprod_reg  <= 40'(sine_q_reg) * 40'(cji_pkg::INV_2PI_Q24);
        if (state_reg == S_PROF)
        begin
            prof_reg <= 18'($signed({1'b0, div_a_reg[16:0]})) - 18'(sterm);
        end
        if (state_reg == S_JMUL)
        begin
            jprod_reg <= 35'($signed(mem_q_reg[32:16])) * 35'(prof_reg);
            start_reg <= $signed(mem_q_reg[15:0]);
        end
        if (out_load)
        begin
            out_word_reg.out_chain      <= chain_reg;
            out_word_reg.out_joint      <= joint_q_reg[2:0];
            out_word_reg.angle          <= angle_sat;
            out_word_reg.chain_finished <= fin_reg;
            out_word_reg.last           <= last_joint;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_word_reg;

    // restart leaves every counter at zero
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && (cmd.data.func == cji_pkg::FUNC_RESTART) |=> !ctr_any)
        else $error("step counter not cleared by restart");

    // k/N never exceeds one once the divider is done
    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIN) |-> (div_a_reg <= DIV_W'(cji_pkg::FRAC_ONE)))
        else $error("profile fraction above one");

    // joint walk stays within the chain's count
    a_joint_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_JRD || state_reg == S_JMUL || state_reg == S_JOUT)
        |-> (joint_q_reg < cnt_reg))
        else $error("joint index beyond chain count");

    // a step of an empty chain only moves its counter
    a_empty_chain: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && (cnt_next == 4'd0) |=> (state_reg == S_IDLE))
        else $error("empty chain started the datapath");

endmodule

FILE: verif/joint_angle_checker.sv
// Scoreboard for the cycloid joint interpolator: watches the command, result and
// register ports, predicts every joint angle word and compares it field by field.
// Depends on cji_pkg and the channel interfaces in cji_stream_if.sv.
module joint_angle_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    cji_cmd_if                              cmd,
    cji_res_if                              res,
    input  logic                            cfg_we,
    input  logic [cji_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cji_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              outstanding,
    output int                              checked
);

    localparam int CHAIN_TOTAL  = 5;
    localparam int JOINTS       = 8;
    localparam int TABLE_SIZE   = 1024;
    localparam int REPORT_LIMIT = 10;
    localparam longint PI_FIXED   = 64'sd3373259426;
    localparam longint UNIT_Q30   = 64'sd1073741824;
    localparam longint INV_TWO_PI = 64'sd2670177;

    int                 sine_q16 [TABLE_SIZE];
    int                 joint_start [CHAIN_TOTAL*JOINTS];
    int                 joint_delta [CHAIN_TOTAL*JOINTS];
    int unsigned        step_ctr [CHAIN_TOTAL];
    int unsigned        joints_in_chain [CHAIN_TOTAL];
    int unsigned        step_count;
    cji_pkg::out_word_t pending_angles [$];
    int                 mismatches;
    int                 matched;

    // one table entry: first quadrant fold, odd series in Q30, round to Q16
    function automatic int sine_entry(int i);
        longint p;
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint r;
        bit     neg;
        int     n;
        p   = 4 * i;
        neg = 1'b0;
        if (p >= 2 * TABLE_SIZE)
        begin
            p   = p - 2 * TABLE_SIZE;
            neg = 1'b1;
        end
        if (p > TABLE_SIZE)
        begin
            p = 2 * TABLE_SIZE - p;
        end
        x    = (p * PI_FIXED + TABLE_SIZE) / (2 * TABLE_SIZE);
        x2   = (x * x) / UNIT_Q30;
        term = x;
        sum  = x;
        for (n = 1; n <= 7; n++)
        begin
            term = -((term * x2) / UNIT_Q30) / longint'((2 * n) * (2 * n + 1));
            sum  = sum + term;
        end
        r = (sum + 64'sd8192) >>> 14;
        if (r < 0)
        begin
            r = 0;
        end
        if (r > 65536)
        begin
            r = 65536;
        end
        return neg ? -int'(r) : int'(r);
    endfunction

    initial
    begin
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            sine_q16[i] = sine_entry(i);
        end
    end

    // apply one command word to the joint store and counters, queue its angles
    task automatic predict_angles(input cji_pkg::in_word_t w);
        int unsigned        c;
        int unsigned        n;
        int unsigned        k;
        int unsigned        kk;
        int unsigned        idx;
        int unsigned        cnt;
        int unsigned        e;
        longint             frac;
        longint             sterm;
        longint             prof;
        longint             a;
        bit                 fin;
        cji_pkg::out_word_t r;
        c = w.chain_sel;
        if (w.func == cji_pkg::FUNC_RESTART)
        begin
            for (int q = 0; q < CHAIN_TOTAL; q++)
            begin
                step_ctr[q] = 0;
            end
            return;
        end
        if (c >= CHAIN_TOTAL)
        begin
            return;
        end
        if (w.func == cji_pkg::FUNC_LOAD)
        begin
            e = c * JOINTS + w.joint_sel;
            joint_start[e] = int'($signed(w.start_angle));
            joint_delta[e] = int'($signed(w.final_angle)) - int'($signed(w.start_angle));
            return;
        end
        if (w.func != cji_pkg::FUNC_STEP)
        begin
            return;
        end

        // counter update; a zero step count behaves as one
        n = (step_count == 0) ? 1 : step_count;
        if (step_ctr[c] < n)
        begin
            step_ctr[c] = step_ctr[c] + 1;
        end
        k   = step_ctr[c];
        fin = (k >= n);
        kk  = (k > n) ? n : k;

        // cycloid profile in Q1.16
        frac = (longint'(kk) <<< 16) / longint'(n);
        idx  = (kk * TABLE_SIZE) / n;
        if (idx >= TABLE_SIZE)
        begin
            idx = idx - TABLE_SIZE;
        end
        sterm = (longint'(sine_q16[idx]) * INV_TWO_PI + (64'sd1 <<< 23)) >>> 24;
        prof  = frac - sterm;

        // one word per joint, saturated to 16 bits
        cnt = joints_in_chain[c];
        if (cnt > JOINTS)
        begin
            cnt = JOINTS;
        end
        for (int unsigned q = 0; q < cnt; q++)
        begin
            e = c * JOINTS + q;
            a = longint'(joint_start[e])
                + ((longint'(joint_delta[e]) * prof + 64'sd32768) >>> 16);
            if (a > 32767)
            begin
                a = 32767;
            end
            if (a < -32768)
            begin
                a = -32768;
            end
            r.out_chain      = 3'(c);
            r.out_joint      = 3'(q);
            r.angle          = 16'(a);
            r.chain_finished = fin;
            r.last           = (q + 1 == cnt);
            pending_angles.insert(pending_angles.size(), r);
        end
    endtask

    // compare one result word with the oldest prediction
    task automatic compare_angle(input cji_pkg::out_word_t got);
        cji_pkg::out_word_t want;
        bit                 bad;
        if (pending_angles.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("unexpected result word: chain %0d joint %0d angle %0d fin %0b last %0b",
                         got.out_chain, got.out_joint, got.angle, got.chain_finished, got.last);
            end
            return;
        end
        want = pending_angles.pop_front();
        bad  = (got.out_chain != want.out_chain) || (got.out_joint != want.out_joint)
               || (got.angle != want.angle) || (got.chain_finished != want.chain_finished)
               || (got.last != want.last);
        if (bad)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("mismatch: expected chain %0d joint %0d angle %0d fin %0b last %0b",
                         want.out_chain, want.out_joint, want.angle, want.chain_finished,
                         want.last);
                $display("          got      chain %0d joint %0d angle %0d fin %0b last %0b",
                         got.out_chain, got.out_joint, got.angle, got.chain_finished, got.last);
            end
        end
        else
        begin
            matched++;
        end
    endtask

    // sample all ports at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count = cji_pkg::STEP_COUNT_RESET;
            for (int q = 0; q < CHAIN_TOTAL; q++)
            begin
                joints_in_chain[q] = cji_pkg::LEN_RESET[q];
                step_ctr[q]        = 0;
            end
            pending_angles.delete();
            mismatches  = 0;
            matched     = 0;
            fail_count  <= 0;
            outstanding <= 0;
            checked     <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == cji_pkg::REG_STEP_COUNT)
                begin
                    step_count = cfg_data;
                end
                else if (cfg_index >= cji_pkg::REG_HEAD && cfg_index <= cji_pkg::REG_RIGHT_ARM)
                begin
                    joints_in_chain[cfg_index - cji_pkg::REG_HEAD] = cfg_data[3:0];
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                predict_angles(cmd.data);
            end
            if (res.valid && res.ready)
            begin
                compare_angle(res.data);
            end
            fail_count  <= mismatches;
            outstanding <= pending_angles.size();
            checked     <= matched;
        end
    end

endmodule

FILE: verif/testbench.sv
// Top of the cycloid joint interpolator bench: clock, reset, command stimulus,
// result-side back-pressure, register settings, watchdog and verdict.
// Depends on cji_pkg, cji_stream_if.sv, the block and joint_angle_checker.
module testbench;

    localparam int CHAIN_TOTAL   = 5;
    localparam int JOINTS        = 8;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we;
    logic [cji_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [cji_pkg::CFG_DATA_W-1:0]  cfg_data;

    int  fail_count;
    int  outstanding;
    int  checked;
    int  cmd_words;
    int  settings_done;
    bit  send_calm;
    bit  hold_req;
    bit  hold_done;
    bit  joint_loaded [CHAIN_TOTAL*JOINTS];
    int  chain_joints [CHAIN_TOTAL];

    cji_cmd_if cmd_ch ();
    cji_res_if res_ch ();

    cycloid_joint_interpolator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    joint_angle_checker angle_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .res         (res_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always #5 clk = ~clk;

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic cji_pkg::in_word_t make_word(logic [1:0] f, int c, int j,
                                                    logic [15:0] s, logic [15:0] t);
        cji_pkg::in_word_t w;
        w.func        = f;
        w.chain_sel   = 3'(c);
        w.joint_sel   = 3'(j);
        w.start_angle = s;
        w.final_angle = t;
        return w;
    endfunction

    // index of the first joint a step would read that was never loaded, or -1
    function automatic int missing_joint(int c);
        for (int q = 0; q < chain_joints[c]; q++)
        begin
            if (!joint_loaded[c*JOINTS+q])
            begin
                return q;
            end
        end
        return -1;
    endfunction

    // offer one command word and wait until it is taken
    task automatic send_word(input cji_pkg::in_word_t w);
        int gap;
        gap = send_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= w;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        cmd_words++;
        if (w.func == cji_pkg::FUNC_LOAD && w.chain_sel < CHAIN_TOTAL)
        begin
            joint_loaded[w.chain_sel*JOINTS+w.joint_sel] = 1'b1;
        end
    endtask

    // drain: nothing expected, then the longest step time
    task automatic settle();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // program step count and the five chain lengths, spare data bits random
    task automatic write_setting(int steps, int l0, int l1, int l2, int l3, int l4);
        int lens [CHAIN_TOTAL];
        lens = '{l0, l1, l2, l3, l4};
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= cji_pkg::REG_STEP_COUNT;
        cfg_data  <= 10'(steps);
        for (int c = 0; c < CHAIN_TOTAL; c++)
        begin
            @(negedge clk);
            cfg_index <= cji_pkg::REG_HEAD + 3'(c);
            cfg_data  <= {6'($urandom_range(0, 63)), 4'(lens[c])};
            chain_joints[c] = (lens[c] > JOINTS) ? JOINTS : lens[c];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_done++;
    endtask

    // one random word; noise words do not count towards the budget
    task automatic random_word(output cji_pkg::in_word_t w, output bit counted);
        int r;
        int c;
        int j;
        int gap_joint;
        r       = $urandom_range(0, 99);
        c       = $urandom_range(0, CHAIN_TOTAL - 1);
        j       = $urandom_range(0, JOINTS - 1);
        counted = 1'b1;
        if (r < 4)
        begin
            w = make_word(FUNC_UNUSED, $urandom_range(0, 7), j, rand_angle(), rand_angle());
            counted = 1'b0;
        end
        else if (r < 8)
        begin
            w = make_word($urandom_range(0, 1) ? cji_pkg::FUNC_STEP : cji_pkg::FUNC_LOAD,
                          $urandom_range(CHAIN_TOTAL, 7), j, rand_angle(), rand_angle());
            counted = 1'b0;
        end
        else if (r < 12)
        begin
            w = make_word(cji_pkg::FUNC_RESTART, $urandom_range(0, 7), j, rand_angle(),
                          rand_angle());
        end
        else if (r < 45)
        begin
            w = make_word(cji_pkg::FUNC_LOAD, c, j, rand_angle(), rand_angle());
        end
        else
        begin
            // never step a chain that still holds an unloaded joint
            gap_joint = missing_joint(c);
            if (gap_joint >= 0)
            begin
                w = make_word(cji_pkg::FUNC_LOAD, c, gap_joint, rand_angle(), rand_angle());
            end
            else
            begin
                w = make_word(cji_pkg::FUNC_STEP, c, j, rand_angle(), rand_angle());
            end
        end
    endtask

    task automatic run_random(int count);
        cji_pkg::in_word_t w;
        bit                counted;
        int                done;
        done = 0;
        while (done < count)
        begin
            random_word(w, counted);
            send_word(w);
            if (counted)
            begin
                done++;
            end
        end
    endtask

    // result side: random stalls, calm stretches, one long hold on request
    initial
    begin
        int stall;
        int calm_left;
        bit calm;
        res_ch.ready = 1'b0;
        hold_done    = 1'b0;
        stall        = 0;
        calm_left    = 0;
        calm         = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            if (calm_left == 0)
            begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(50, 200);
            end
            else
            begin
                calm_left--;
            end
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (!calm)
                begin
                    stall = pick_gap();
                end
            end
        end
    end

    // watchdog on cycles with no word taken on either channel
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || !rst_n)
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
        end
        $display("watchdog: no word taken for %0d cycles", IDLE_LIMIT);
        $display("FAIL cycloid_joint_interpolator");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        cmd_ch.valid  = 1'b0;
        cmd_ch.data   = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        hold_req      = 1'b0;
        send_calm     = 1'b1;
        cmd_words     = 0;
        settings_done = 1;
        for (int q = 0; q < CHAIN_TOTAL*JOINTS; q++)
        begin
            joint_loaded[q] = 1'b0;
        end
        for (int c = 0; c < CHAIN_TOTAL; c++)
        begin
            chain_joints[c] = cji_pkg::LEN_RESET[c];
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: one step to the final pose, held counter, ignored words
        send_word(make_word(cji_pkg::FUNC_LOAD, 0, 0, 16'h7fff, 16'h8000));
        send_word(make_word(cji_pkg::FUNC_LOAD, 0, 1, 16'h8000, 16'h7fff));
        send_word(make_word(cji_pkg::FUNC_STEP, 0, 0, 16'h0000, 16'h0000));
        send_word(make_word(cji_pkg::FUNC_STEP, 0, 7, 16'hffff, 16'hffff));
        send_word(make_word(FUNC_UNUSED, 6, 5, 16'h5a5a, 16'ha5a5));
        send_word(make_word(cji_pkg::FUNC_LOAD, 7, 7, 16'h1234, 16'h4321));
        send_word(make_word(cji_pkg::FUNC_STEP, 5, 0, 16'h0000, 16'h0000));
        send_word(make_word(cji_pkg::FUNC_RESTART, 3, 2, 16'h0000, 16'h0000));
        send_word(make_word(cji_pkg::FUNC_STEP, 0, 0, 16'h0000, 16'h0000));
        settle();

        // longest step count, full head, empty left arm, oversized left leg
        write_setting(1023, 8, 0, 15, 1, 3);
        for (int q = 0; q < JOINTS; q++)
        begin
            case (q % 4)
                0: send_word(make_word(cji_pkg::FUNC_LOAD, 0, q, 16'h7fff, 16'h8000));
                1: send_word(make_word(cji_pkg::FUNC_LOAD, 0, q, 16'h8000, 16'h7fff));
                2: send_word(make_word(cji_pkg::FUNC_LOAD, 0, q, 16'h0000, 16'h0000));
                default: send_word(make_word(cji_pkg::FUNC_LOAD, 0, q, 16'h2000, 16'h2000));
            endcase
        end
        send_word(make_word(cji_pkg::FUNC_STEP, 0, 0, 16'h0000, 16'h0000));
        send_word(make_word(cji_pkg::FUNC_STEP, 0, 0, 16'h0000, 16'h0000));
        send_word(make_word(cji_pkg::FUNC_STEP, 1, 0, 16'h0000, 16'h0000));
        settle();

        // mid step count with random traffic, then run chain 0 ahead
        send_calm = 1'b0;
        write_setting(12, 8, 3, 15, 5, 2);
        run_random(24);
        for (int s = 0; s < 6; s++)
        begin
            send_word(make_word(cji_pkg::FUNC_STEP, 0, s, rand_angle(), rand_angle()));
        end
        settle();

        // step count lowered under the counters; long hold on the result side
        write_setting(4, 5, 8, 1, 4, 6);
        hold_req  = 1'b1;
        send_calm = 1'b1;
        run_random(25);
        settle();

        // zero step count behaves as one
        send_calm = 1'b0;
        write_setting(0, 0, 2, 8, 7, 3);
        run_random(20);
        settle();

        // short profile with the reset lengths
        write_setting(7, 2, 4, 6, 6, 4);
        run_random(12);
        settle();

        $display("covered %0d command words and %0d checked angle words over %0d settings",
                 cmd_words, checked, settings_done);
        $display("step counts 0, 1, 4, 7, 12 and 1023; chain lengths 0 to 15; one long hold");
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("PASS cycloid_joint_interpolator");
        end
        else
        begin
            $display("FAIL cycloid_joint_interpolator");
        end
        $finish;
    end

endmodule
